// ===== rtl/core/grid_astar_path_search_top_assert.svh =====
// Assertion macros for the grid path search block.
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_ASSERT_SVH
`define GAPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GAPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/gaps_pkg.sv =====
// Package with shared types and codes of the grid path search block.
package gaps_pkg;
  typedef enum logic [1:0] {
    StatusPoint    = 2'd0,
    StatusNoPath   = 2'd1,
    StatusOverflow = 2'd2
  } status_e;
  localparam logic OpLoad   = 1'b0;
  localparam logic OpSearch = 1'b1;
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;
  localparam logic [1:0] DirDown  = 2'd2;
  localparam logic [1:0] DirLeft  = 2'd3;
endpackage

// ===== rtl/core/grid_astar_path_search_top.sv =====
// Top level of the grid A* path search block.
//
// Channel   Handshake            Fields
// request   start_i, busy_o      opcode_i cell_x_i cell_y_i walkable_i start/end x,y
// result    result_valid_o       pos_x_o pos_y_o step_index_o status_o last_o
//
// After reset a fill pass marks every cell walkable; busy_o is high meanwhile.
// A load request is written while the block stays idle. A search clears its cell
// tables, then pops the open list by a scan in SScan and SScanWait per entry, shifts
// the tail up in SPopRd and SPop per entry, and visits four neighbors in SNbr, SNbrRd
// and SNbrChk. The walk back steps SWalk, SEmit per point; results go via SWalkRd, SDone.
// The receiver cannot stall; busy_o is low only in the idle state.
module grid_astar_path_search_top #(
  parameter int GRID_W     = 8,
  parameter int GRID_H     = 8,
  parameter int OPEN_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       opcode_i,
  input  logic [2:0] cell_x_i,
  input  logic [2:0] cell_y_i,
  input  logic       walkable_i,
  input  logic [2:0] start_x_i,
  input  logic [2:0] start_y_i,
  input  logic [2:0] end_x_i,
  input  logic [2:0] end_y_i,
  output logic       result_valid_o,
  output logic [2:0] pos_x_o,
  output logic [2:0] pos_y_o,
  output logic [5:0] step_index_o,
  output gaps_pkg::status_e status_o,
  output logic       last_o
);
  import gaps_pkg::*;

  localparam int OW = $clog2(OPEN_DEPTH);
  localparam int CW = OW + 1;

  typedef enum logic [3:0] {
    SFill, SIdle, SClear, SInit, SScan, SScanWait, SPopRd, SPop, SNbr, SNbrRd,
    SNbrChk, SWalk, SWalkRd, SEmit, SDone
  } state_e;

  typedef struct packed {
    logic [5:0] loc;
    logic [6:0] g;
    logic [6:0] f;
  } entry_t;

  logic       walk_mem [64];
  logic [6:0] cost_mem [64];
  logic       seen_mem [64];
  logic [1:0] par_mem  [64];
  entry_t     open_mem [OPEN_DEPTH];
  logic [5:0] stk_mem  [64];

  state_e     state_q;
  logic [CW-1:0] cnt_q, idx_q, pick_q;
  logic [6:0] bestf_q;
  logic [5:0] clr_q;
  logic [2:0] sx_q, sy_q, ex_q, ey_q, cx_q, cy_q, nx_q, ny_q;
  logic [6:0] g_q;
  logic [1:0] d_q;
  logic       nvalid_q;
  logic [6:0] nf_q;
  logic [6:0] n_q, k_q;
  logic       walk_rd_q, seen_rd_q;
  logic [6:0] cost_rd_q;
  logic [1:0] par_rd_q;
  entry_t     open_rd_q;
  logic [5:0] stk_rd_q;
  logic [OW-1:0] open_ra, open_wa;
  logic       open_we;
  entry_t     open_wd;
  logic       res_valid_d;

  function automatic logic [2:0] adist(input logic [2:0] a, input logic [2:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk_i) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    open_rd_q <= open_mem[open_ra];
  end

  logic [5:0] ncell;
  assign ncell = {ny_q, nx_q};
  logic [5:0] ccell;
  assign ccell = {cy_q, cx_q};
  logic out_start, out_end;
  assign out_start = (32'(start_x_i) >= GRID_W) || (32'(start_y_i) >= GRID_H);
  assign out_end   = (32'(end_x_i) >= GRID_W) || (32'(end_y_i) >= GRID_H);

  logic [2:0] tx, ty;
  logic       tval;
  always_comb begin
    tx = cx_q; ty = cy_q; tval = 1'b1;
    case (d_q)
      DirUp:    begin ty = cy_q - 3'd1; tval = cy_q != 3'd0; end
      DirRight: begin tx = cx_q + 3'd1; tval = 32'(cx_q) + 1 < GRID_W; end
      DirDown:  begin ty = cy_q + 3'd1; tval = 32'(cy_q) + 1 < GRID_H; end
      DirLeft:  begin tx = cx_q - 3'd1; tval = cx_q != 3'd0; end
      default:  tval = 1'b0;
    endcase
  end

  logic [2:0] bx, by;
  always_comb begin
    bx = cx_q; by = cy_q;
    case (par_rd_q)
      DirUp:    by = cy_q + 3'd1;
      DirRight: bx = cx_q - 3'd1;
      DirDown:  by = cy_q - 3'd1;
      DirLeft:  bx = cx_q + 3'd1;
      default:  bx = cx_q;
    endcase
  end

  logic accept, nok, ovf;
  assign accept = start_i && !busy_o;
  assign nok = walk_rd_q && !(seen_rd_q && (g_q + 7'd1 >= cost_rd_q));
  assign ovf = nvalid_q && nok && (cnt_q >= CW'(OPEN_DEPTH));

  always_comb begin
    open_we = 1'b0;
    open_wa = cnt_q[OW-1:0];
    open_wd = '{loc: ncell, g: g_q + 7'd1, f: nf_q};
    open_ra = idx_q[OW-1:0];
    case (state_q)
      SInit: begin
        open_we = 1'b1;
        open_wa = '0;
        open_wd = '{loc: {sy_q, sx_q}, g: 7'd0,
                    f: 7'(adist(sx_q, ex_q)) + 7'(adist(sy_q, ey_q))};
      end
      SPop: begin
        open_we = 1'b1;
        open_wa = idx_q[OW-1:0] - OW'(1);
        open_wd = open_rd_q;
      end
      SNbrChk: open_we = nvalid_q && nok && (cnt_q < CW'(OPEN_DEPTH));
      default: open_we = 1'b0;
    endcase
  end

  always_comb begin
    res_valid_d = 1'b0;
    case (state_q)
      SIdle:   res_valid_d = accept && opcode_i == OpSearch && (out_start || out_end);
      SScan:   res_valid_d = cnt_q == '0;
      SNbrChk: res_valid_d = ovf;
      SDone:   res_valid_d = 1'b1;
      default: res_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    walk_rd_q <= walk_mem[ncell];
    seen_rd_q <= seen_mem[ncell];
    cost_rd_q <= cost_mem[ncell];
    par_rd_q  <= par_mem[ccell];
    stk_rd_q  <= stk_mem[6'(k_q)];
    if (state_q == SFill) walk_mem[clr_q] <= 1'b1;
    if (state_q == SClear) begin
      seen_mem[clr_q] <= 1'b0;
      cost_mem[clr_q] <= 7'd0;
    end
    if (state_q == SInit) seen_mem[{sy_q, sx_q}] <= 1'b1;
    if (state_q == SNbrChk && open_we) begin
      seen_mem[ncell] <= 1'b1;
      cost_mem[ncell] <= g_q + 7'd1;
      par_mem[ncell]  <= d_q;
    end
    if (state_q == SWalk) stk_mem[6'(n_q)] <= ccell;
    if (accept && opcode_i == OpLoad && 32'(cell_x_i) < GRID_W && 32'(cell_y_i) < GRID_H)
      walk_mem[{cell_y_i, cell_x_i}] <= walkable_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SFill;
      result_valid_o <= 1'b0;
      cnt_q <= '0; idx_q <= '0; pick_q <= '0; clr_q <= '0;
      n_q <= '0; k_q <= '0;
    end else begin
      result_valid_o <= res_valid_d;
      case (state_q)
        SFill: begin
          clr_q <= clr_q + 6'd1;
          if (clr_q == 6'd63) state_q <= SIdle;
        end
        SIdle: if (accept && opcode_i == OpSearch) begin
          sx_q <= start_x_i; sy_q <= start_y_i; ex_q <= end_x_i; ey_q <= end_y_i;
          cnt_q <= '0; clr_q <= '0;
          if (out_start || out_end) begin
            pos_x_o <= '0; pos_y_o <= '0; step_index_o <= '0;
            status_o <= StatusNoPath; last_o <= 1'b1;
          end else state_q <= SClear;
        end
        SClear: begin
          clr_q <= clr_q + 6'd1;
          if (clr_q == 6'd63) state_q <= SInit;
        end
        SInit: begin
          cnt_q <= CW'(1); idx_q <= '0; pick_q <= '0; bestf_q <= 7'h7f;
          state_q <= SScan;
        end
        SScan: begin
          if (cnt_q == '0) begin
            pos_x_o <= '0; pos_y_o <= '0; step_index_o <= '0;
            status_o <= StatusNoPath; last_o <= 1'b1;
            state_q <= SIdle;
          end else state_q <= SScanWait;
        end
        SScanWait: begin
          if (open_rd_q.f <= bestf_q) begin
            bestf_q <= open_rd_q.f; pick_q <= idx_q;
            cx_q <= open_rd_q.loc[2:0];
            cy_q <= open_rd_q.loc[5:3];
            g_q <= open_rd_q.g;
          end
          if (idx_q + CW'(1) == cnt_q) begin
            idx_q <= (open_rd_q.f <= bestf_q) ? idx_q + CW'(1) : pick_q + CW'(1);
            state_q <= SPopRd;
          end else begin
            idx_q <= idx_q + CW'(1);
            state_q <= SScan;
          end
        end
        SPopRd: begin
          if (idx_q == cnt_q) begin
            cnt_q <= cnt_q - CW'(1);
            d_q <= DirUp;
            if (cx_q == ex_q && cy_q == ey_q) begin
              n_q <= '0; state_q <= SWalk;
            end else state_q <= SNbr;
          end else state_q <= SPop;
        end
        SPop: begin
          idx_q <= idx_q + CW'(1);
          state_q <= SPopRd;
        end
        SNbr: begin
          nx_q <= tx; ny_q <= ty; nvalid_q <= tval;
          nf_q <= g_q + 7'd1 + 7'(adist(tx, ex_q)) + 7'(adist(ty, ey_q));
          state_q <= SNbrRd;
        end
        SNbrRd: state_q <= SNbrChk;
        SNbrChk: begin
          if (ovf) begin
            pos_x_o <= '0; pos_y_o <= '0; step_index_o <= '0;
            status_o <= StatusOverflow; last_o <= 1'b1;
            state_q <= SIdle;
          end else begin
            if (open_we) cnt_q <= cnt_q + CW'(1);
            d_q <= d_q + 2'd1;
            if (d_q == DirLeft) begin
              idx_q <= '0; pick_q <= '0; bestf_q <= 7'h7f;
              state_q <= SScan;
            end else state_q <= SNbr;
          end
        end
        SWalk: begin
          n_q <= n_q + 7'd1;
          if ((cx_q == sx_q && cy_q == sy_q) || n_q == 7'd63) begin
            k_q <= n_q; state_q <= SWalkRd;
          end else state_q <= SEmit;
        end
        SEmit: begin
          cx_q <= bx; cy_q <= by;
          state_q <= SWalk;
        end
        SWalkRd: state_q <= SDone;
        SDone: begin
          pos_x_o <= stk_rd_q[2:0];
          pos_y_o <= stk_rd_q[5:3];
          step_index_o <= 6'(n_q - 7'd1 - k_q);
          status_o <= StatusPoint;
          last_o <= (k_q == 7'd0);
          if (k_q == 7'd0) state_q <= SIdle;
          else begin
            k_q <= k_q - 7'd1;
            state_q <= SWalkRd;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign busy_o = state_q != SIdle;
endmodule

// ===== rtl/core/gaps_checker.sv =====
// Port checker for the grid path search block, with its bind.
`include "grid_astar_path_search_top_assert.svh"
module gaps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o,
  input logic [1:0] status_o,
  input logic last_o,
  input logic [5:0] step_index_o
);
  import gaps_pkg::*;

  `GAPS_ASSERT_IMPL(status_range, result_valid_o, status_o <= StatusOverflow)
  `GAPS_ASSERT_IMPL(status_last, result_valid_o && status_o != StatusPoint, last_o)
  `GAPS_ASSERT_IMPL(status_step, result_valid_o && status_o != StatusPoint, step_index_o == 6'd0)
  `GAPS_ASSERT_IMPL(idle_on_last, result_valid_o && last_o, !busy_o)
  `GAPS_ASSERT_NEXT(idle_after_last, result_valid_o && last_o && !start_i, !busy_o)
endmodule

bind grid_astar_path_search_top gaps_checker u_gaps_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .result_valid_o(result_valid_o), .status_o(status_o), .last_o(last_o),
  .step_index_o(step_index_o)
);
